[sv/rs485_command_framer_unit_macros.svh]
// Assertion macros shared by the checker of the command framer.
`ifndef RS485_COMMAND_FRAMER_UNIT_MACROS_SVH
`define RS485_COMMAND_FRAMER_UNIT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define RS485CF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked implication, switched off while reset is asserted.
`define RS485CF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/rs485cf_pkg.sv]
// Package with the types and constants of the command framer.
`timescale 1ns / 1ps
package rs485cf_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] SYNC_FIRST  = 8'hEB;
  localparam logic [7:0] SYNC_SECOND = 8'h90;
  localparam logic [7:0] LEN_MAX     = 8'd254;

  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] HDR_STEP_SYNC1 = 3'd0;
  localparam logic [STEP_W-1:0] HDR_STEP_SYNC2 = 3'd1;
  localparam logic [STEP_W-1:0] HDR_STEP_ID    = 3'd2;
  localparam logic [STEP_W-1:0] HDR_STEP_LEN   = 3'd3;
  localparam logic [STEP_W-1:0] HDR_STEP_CMD   = 3'd4;
  localparam logic [STEP_W-1:0] HDR_STEP_SUM   = 3'd5;
  localparam logic [STEP_W-1:0] PAY_STEP_DATA  = 3'd0;
  localparam logic [STEP_W-1:0] PAY_STEP_SUM   = 3'd1;

  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_PAYLOAD = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_ABORTED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_HEADER  = 2'd0,
    JOB_PAYLOAD = 2'd1,
    JOB_ERROR   = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] frame_id;
    logic [7:0] command;
    logic [7:0] payload_len;
    logic [7:0] payload_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    status_e    status;
  } rsp_t;

  typedef struct packed {
    job_kind_e  kind;
    status_e    status;
    logic       is_last;
    logic [7:0] first_byte;
    logic [7:0] command;
    logic [7:0] len_byte;
    logic [7:0] checksum;
  } job_t;

endpackage

[sv/rs485cf_front.sv]
// Front end: accepts requests, tracks the open frame and queues byte jobs.
`timescale 1ns / 1ps
module rs485cf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rs485cf_pkg::req_t   in_data_i,
  output logic                push_o,
  output rs485cf_pkg::job_t   job_o,
  input  logic                full_i
);
  import rs485cf_pkg::*;

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] len_sat, len_byte, hdr_sum, pay_sum, left_dec;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  assign len_sat  = (in_data_i.payload_len > LEN_MAX) ? LEN_MAX : in_data_i.payload_len;
  assign len_byte = len_sat + 8'd1;
  assign hdr_sum  = in_data_i.frame_id + len_byte + in_data_i.command;
  assign pay_sum  = sum_q + in_data_i.payload_byte;
  assign left_dec = left_q - 8'd1;

  always_comb begin
    open_d           = open_q;
    left_d           = left_q;
    sum_d            = sum_q;
    job_o.kind       = JOB_ERROR;
    job_o.status     = ST_NO_FRAME;
    job_o.is_last    = 1'b0;
    job_o.first_byte = 8'd0;
    job_o.command    = in_data_i.command;
    job_o.len_byte   = len_byte;
    job_o.checksum   = hdr_sum;
    if (in_data_i.req_type == REQ_START) begin
      job_o.kind       = JOB_HEADER;
      job_o.status     = open_q ? ST_ABORTED : ST_OK;
      job_o.is_last    = (len_sat == 8'd0);
      job_o.first_byte = in_data_i.frame_id;
      open_d           = (len_sat != 8'd0);
      left_d           = len_sat;
      sum_d            = (len_sat == 8'd0) ? 8'd0 : hdr_sum;
    end else if (open_q) begin
      job_o.kind       = JOB_PAYLOAD;
      job_o.status     = ST_OK;
      job_o.is_last    = (left_dec == 8'd0);
      job_o.first_byte = in_data_i.payload_byte;
      job_o.checksum   = pay_sum;
      open_d           = (left_dec != 8'd0);
      left_d           = left_dec;
      sum_d            = (left_dec == 8'd0) ? 8'd0 : pay_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
      sum_q  <= 8'd0;
    end else if (push_o) begin
      open_q <= open_d;
      left_q <= left_d;
      sum_q  <= sum_d;
    end
  end

endmodule

[sv/rs485cf_queue.sv]
// Short register queue of byte jobs between the front and back ends.
`timescale 1ns / 1ps
module rs485cf_queue #(
  parameter int unsigned Depth = rs485cf_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rs485cf_pkg::job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output rs485cf_pkg::job_t head_o,
  output logic              empty_o
);
  import rs485cf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[sv/rs485cf_back.sv]
// Back end: walks each queued job and emits one frame byte per cycle while its output is not stalled.
`timescale 1ns / 1ps
module rs485cf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rs485cf_pkg::job_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rs485cf_pkg::rsp_t out_data_o
);
  import rs485cf_pkg::*;

  logic [STEP_W-1:0] step_q, step_d, final_step;
  logic              load;
  logic              valid_q, valid_d;
  rsp_t              data_q, data_d;

  assign load = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    unique case (head_i.kind)
      JOB_HEADER:  final_step = head_i.is_last ? HDR_STEP_SUM : HDR_STEP_CMD;
      JOB_PAYLOAD: final_step = head_i.is_last ? PAY_STEP_SUM : PAY_STEP_DATA;
      default:     final_step = PAY_STEP_DATA;
    endcase
  end

  always_comb begin
    data_d.status    = head_i.status;
    data_d.frame_end = 1'b0;
    data_d.out_byte  = head_i.first_byte;
    if (head_i.kind == JOB_HEADER) begin
      unique case (step_q)
        HDR_STEP_SYNC1: data_d.out_byte = SYNC_FIRST;
        HDR_STEP_SYNC2: data_d.out_byte = SYNC_SECOND;
        HDR_STEP_ID:    data_d.out_byte = head_i.first_byte;
        HDR_STEP_LEN:   data_d.out_byte = head_i.len_byte;
        HDR_STEP_CMD:   data_d.out_byte = head_i.command;
        default: begin
          data_d.out_byte  = head_i.checksum;
          data_d.frame_end = 1'b1;
        end
      endcase
    end else if (head_i.kind == JOB_PAYLOAD && step_q == PAY_STEP_SUM) begin
      data_d.out_byte  = head_i.checksum;
      data_d.frame_end = 1'b1;
    end
  end

  assign pop_o   = load && (step_q == final_step);
  assign step_d  = pop_o ? '0 : (load ? step_q + STEP_W'(1) : step_q);
  assign valid_d = load ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[sv/rs485_command_framer_unit.sv]
// Top level of the command framer: front end, job queue and byte back end.
// A request is taken in every cycle while the job queue has room.
// A request's first byte is valid after the job queue and the output register.
// The back end emits one byte per cycle when not stalled; a start request gives
// 5 or 6 bytes, a payload request 1 or 2, a stray payload byte 1.
// Reset clears the frame state, empties the queue and drops the output byte.
`timescale 1ns / 1ps
module rs485_command_framer_unit #(
  parameter int unsigned QueueDepth = rs485cf_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rs485cf_pkg::req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rs485cf_pkg::rsp_t out_data_o
);
  import rs485cf_pkg::*;

  job_t push_job, head_job;
  logic push, full, pop, empty;

  rs485cf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  rs485cf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (empty)
  );

  rs485cf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/rs485cf_checker.sv]
// Port checker for the command framer and its bind to the top level.
`timescale 1ns / 1ps
`include "rs485_command_framer_unit_macros.svh"
module rs485cf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input rs485cf_pkg::req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rs485cf_pkg::rsp_t out_data_o
);
  import rs485cf_pkg::*;

  `RS485CF_ASSERT_IMP(a_out_hold, out_valid_o && out_stall_i, ##1 (out_valid_o && $stable(out_data_o)), "stalled output transaction changed")
  `RS485CF_ASSERT_IMP(a_err_shape, out_valid_o && out_data_o.status == ST_NO_FRAME, out_data_o.out_byte == 8'd0 && !out_data_o.frame_end, "stray byte result malformed")
  `RS485CF_ASSERT_IMP(a_end_status, out_valid_o && out_data_o.frame_end, out_data_o.status != ST_NO_FRAME, "checksum byte flagged as stray")
  `RS485CF_ASSERT(a_idle_after_reset, $rose(rst_ni) |-> !out_valid_o, "output valid straight after reset")

endmodule

bind rs485_command_framer_unit rs485cf_checker u_checker (.*);
